FILE: hw/rtl/idc_pkg.sv
// Shared types and codes of the interleaved dropout counter.
package idc_pkg;

  // Action codes carried with each sample.
  localparam logic [1:0] ACT_NEXT      = 2'd0;
  localparam logic [1:0] ACT_FILE      = 2'd1;
  localparam logic [1:0] ACT_MEAS      = 2'd2;
  localparam logic [1:0] ACT_MEAS_ALT  = 2'd3;

  // Configuration register indexes.
  localparam logic REG_CHANNEL_COUNT = 1'b0;
  localparam logic REG_FRAME_SIZE    = 1'b1;

  localparam int RUN_W   = 16;
  localparam int TOTAL_W = 32;

  localparam logic [6:0]  CHANNEL_COUNT_RST = 7'd5;
  localparam logic [15:0] FRAME_SIZE_RST    = 16'd74;

  // One channel's state word in the state memory.
  typedef struct packed {
    logic [RUN_W-1:0]   run;
    logic [TOTAL_W-1:0] total;
  } entry_t;

endpackage

FILE: hw/rtl/interleaved_dropout_counter.sv
// Top level of the interleaved dropout counter.
//
// Samples of several channels arrive interleaved round robin on the input
// channel (in_valid / in_stall, fields action and sample). Each accepted beat
// gives exactly one result beat (out_valid / out_stall, fields channel,
// frame_lost and lost_total) in the same order.
// An accepted sample is registered in the working stage, then in the output
// register. Throughput: one sample per cycle unless the receiver stalls.
// Per-channel run counters and lost-frame totals sit in one state memory; each
// sample is a read issued at accept and a write-back as it leaves the working
// stage, with forwarding between neighbouring samples.
// Action codes other than ACT_NEXT clear the run counters (the measurement codes
// also the totals) at once through a valid bit per channel; no clearing pass is needed.
// Configuration (cfg_valid / cfg_ready, cfg_index, cfg_data) is always ready;
// the user must write it only while the block is idle; the block does not enforce this.
// Reset (rst, synchronous) restores channel count 5, frame size 74, clears the
// pointer and marks every channel's state as zero.
// When the receiver stalls, the result holds; one more sample is taken into
// the working stage, after which in_stall rises until the result is taken.
module interleaved_dropout_counter #(
  parameter int MAX_CHANNELS = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          action,
  input  logic signed [23:0]  sample,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [5:0]          channel,
  output logic                frame_lost,
  output logic [31:0]         lost_total,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [15:0]         cfg_data
);

  localparam int CHW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  // Configuration
  logic [6:0]  channel_count;
  logic [15:0] frame_size;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count <= idc_pkg::CHANNEL_COUNT_RST;
      frame_size    <= idc_pkg::FRAME_SIZE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        idc_pkg::REG_CHANNEL_COUNT: channel_count <= cfg_data[6:0];
        idc_pkg::REG_FRAME_SIZE:    frame_size    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective channel count, clamped to 1..MAX_CHANNELS
  logic [CHW:0] eff_n;
  always_comb begin
    if (channel_count == 7'd0) begin
      eff_n = (CHW+1)'(1);
    end else if ({2'b00, channel_count} > 9'(MAX_CHANNELS)) begin
      eff_n = (CHW+1)'(MAX_CHANNELS);
    end else begin
      eff_n = (CHW+1)'(channel_count);
    end
  end

  // Accept stage
  logic           accept;
  logic           advance;
  logic           clr_run;
  logic           clr_tot;
  logic [CHW-1:0] ptr;
  logic [CHW-1:0] ch_in;
  logic [CHW:0]   ch_inc;

  logic           s1_valid;
  logic [CHW-1:0] s1_ch;
  logic           s1_zero;
  logic           s1_clr_run;
  logic           s1_clr_tot;

  assign accept   = in_valid && !in_stall;
  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;

  assign clr_run = (action != idc_pkg::ACT_NEXT);
  assign clr_tot = action inside {idc_pkg::ACT_MEAS, idc_pkg::ACT_MEAS_ALT};
  assign ch_in   = clr_run ? '0 : ptr;
  assign ch_inc  = {1'b0, ch_in} + (CHW+1)'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr      <= '0;
      s1_valid <= 1'b0;
    end else begin
      if (accept) begin
        ptr <= (ch_inc >= eff_n) ? '0 : ch_inc[CHW-1:0];
      end
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ch      <= ch_in;
      s1_zero    <= (sample == 24'sd0);
      s1_clr_run <= clr_run;
      s1_clr_tot <= clr_tot;
    end
  end

  // State memory and per-channel valid bits
  idc_pkg::entry_t rd_entry;
  idc_pkg::entry_t wr_entry;

  idc_ram #(
    .WIDTH ($bits(idc_pkg::entry_t)),
    .DEPTH (MAX_CHANNELS)
  ) u_state (
    .clk   (clk),
    .we    (advance),
    .waddr (s1_ch),
    .wdata (wr_entry),
    .re    (accept),
    .raddr (ch_in),
    .rdata (rd_entry)
  );

  logic [MAX_CHANNELS-1:0] run_valid;
  logic [MAX_CHANNELS-1:0] tot_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      run_valid <= '0;
      tot_valid <= '0;
    end else begin
      // a clear arriving with the next sample wins over the write-back
      if (accept && clr_run) begin
        run_valid <= '0;
      end else if (advance) begin
        run_valid[s1_ch] <= 1'b1;
      end
      if (accept && clr_tot) begin
        tot_valid <= '0;
      end else if (advance) begin
        tot_valid[s1_ch] <= 1'b1;
      end
    end
  end

  // Forward the write-back that landed at the same edge as this read
  logic            fwd_hit;
  logic [CHW-1:0]  fwd_ch;
  idc_pkg::entry_t fwd_entry;

  // hold the hit while the working stage is held
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else if (accept) begin
      fwd_hit <= advance;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      fwd_ch    <= s1_ch;
      fwd_entry <= wr_entry;
    end
  end

  // Read-modify-write
  logic                        hit_run;
  logic                        hit_tot;
  logic [idc_pkg::RUN_W-1:0]   run_old;
  logic [idc_pkg::RUN_W-1:0]   run_inc;
  logic [idc_pkg::TOTAL_W-1:0] tot_old;
  logic                        lost;

  assign hit_run = fwd_hit && (fwd_ch == s1_ch) && !s1_clr_run;
  assign hit_tot = fwd_hit && (fwd_ch == s1_ch) && !s1_clr_tot;

  always_comb begin
    if (hit_run) begin
      run_old = fwd_entry.run;
    end else if (run_valid[s1_ch]) begin
      run_old = rd_entry.run;
    end else begin
      run_old = '0;
    end

    if (hit_tot) begin
      tot_old = fwd_entry.total;
    end else if (tot_valid[s1_ch]) begin
      tot_old = rd_entry.total;
    end else begin
      tot_old = '0;
    end

    run_inc = s1_zero ? run_old + idc_pkg::RUN_W'(1) : '0;
    lost    = (run_inc == frame_size);

    wr_entry.run = lost ? '0 : run_inc;
    // saturate the total at its maximum
    if (lost && (tot_old != '1)) begin
      wr_entry.total = tot_old + idc_pkg::TOTAL_W'(1);
    end else begin
      wr_entry.total = tot_old;
    end
  end

  // Output register
  logic [CHW+5:0] ch_ext;
  assign ch_ext = {6'b000000, s1_ch};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      channel    <= ch_ext[5:0];
      frame_lost <= lost;
      lost_total <= wr_entry.total;
    end
  end

`ifndef NO_ASSERTIONS
  assert property (@(posedge clk) disable iff (rst) in_stall |-> s1_valid && out_valid)
    else $error("input stalled with a free working stage");

  assert property (@(posedge clk) disable iff (rst) accept |=> s1_valid)
    else $error("accepted beat missing from working stage");

  assert property (@(posedge clk) disable iff (rst)
    s1_valid && !advance |=> s1_valid && $stable(s1_ch) && $stable(s1_zero))
    else $error("held working stage changed");

  assert property (@(posedge clk) disable iff (rst) out_valid && frame_lost |-> lost_total != 0)
    else $error("lost frame reported with zero total");
`endif

endmodule

FILE: hw/rtl/idc_ram.sv
// Simple dual-port synchronous RAM with registered read.
module idc_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: verif/tb_interleaved_dropout_counter.sv
// Testbench of the interleaved dropout counter: random and directed samples against a scoreboard.
`timescale 1ns / 100ps

module tb_interleaved_dropout_counter;

  localparam int MAX_CH     = 64;
  localparam int IDLE_LIMIT = 5000;

  typedef struct packed {
    logic [5:0]  ch;
    logic        lost;
    logic [31:0] total;
  } drop_result_t;

  // Tracks per-channel zero runs and lost-frame totals, and queues the
  // result beat that each accepted sample should give.
  class dropout_scoreboard;
    logic [6:0]   chan_count_q;
    logic [15:0]  frame_size_q;
    logic [15:0]  run_len [MAX_CH];
    logic [31:0]  lost_cnt [MAX_CH];
    int unsigned  next_chan;
    drop_result_t expected_q [$];
    int unsigned  fails;

    function new();
      chan_count_q = idc_pkg::CHANNEL_COUNT_RST;
      frame_size_q = idc_pkg::FRAME_SIZE_RST;
      for (int i = 0; i < MAX_CH; i++) begin
        run_len[i]  = '0;
        lost_cnt[i] = '0;
      end
      next_chan = 0;
      fails     = 0;
    endfunction

    function void set_register(logic idx, logic [15:0] data);
      if (idx == idc_pkg::REG_CHANNEL_COUNT) begin
        chan_count_q = data[6:0];
      end else begin
        frame_size_q = data;
      end
    endfunction

    function int unsigned outstanding();
      return expected_q.size();
    endfunction

    function void note_sample(logic [1:0] act, logic [23:0] smp);
      int unsigned  n;
      int unsigned  c;
      drop_result_t r;
      if (act != idc_pkg::ACT_NEXT) begin
        for (int i = 0; i < MAX_CH; i++) begin
          run_len[i] = '0;
          if (act == idc_pkg::ACT_MEAS || act == idc_pkg::ACT_MEAS_ALT) lost_cnt[i] = '0;
        end
        next_chan = 0;
      end
      // Clamp the channel count to 1..MAX_CH
      n = (chan_count_q == 0) ? 1 : ((chan_count_q > MAX_CH) ? MAX_CH : chan_count_q);
      c = next_chan;
      if (smp == '0) begin
        run_len[c] = run_len[c] + 16'd1;
      end else begin
        run_len[c] = '0;
      end
      r.lost = 1'b0;
      if (run_len[c] == frame_size_q) begin
        run_len[c] = '0;
        r.lost     = 1'b1;
        if (lost_cnt[c] != '1) lost_cnt[c] = lost_cnt[c] + 32'd1;
      end
      next_chan = (c + 1 >= n) ? 0 : c + 1;
      r.ch      = c[5:0];
      r.total   = lost_cnt[c];
      expected_q.push_back(r);
    endfunction

    function void check_result(logic [5:0] ch, logic lost, logic [31:0] total);
      drop_result_t e;
      if (expected_q.size() == 0) begin
        $error("result beat with nothing expected: channel %0d", ch);
        fails++;
        return;
      end
      e = expected_q.pop_front();
      if (ch !== e.ch) begin
        $error("channel: expected %0d, got %0d", e.ch, ch);
        fails++;
      end
      if (lost !== e.lost) begin
        $error("frame_lost: expected %0d, got %0d", e.lost, lost);
        fails++;
      end
      if (total !== e.total) begin
        $error("lost_total: expected %0d, got %0d", e.total, total);
        fails++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         action = idc_pkg::ACT_NEXT;
  logic signed [23:0] sample = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [5:0]         channel;
  logic               frame_lost;
  logic [31:0]        lost_total;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic               cfg_index = idc_pkg::REG_CHANNEL_COUNT;
  logic [15:0]        cfg_data = '0;

  int unsigned        in_idle_pct  = 0;
  int unsigned        out_idle_pct = 0;
  int unsigned        quiet_cycles = 0;
  dropout_scoreboard  sb = new();

  always #5 clk = ~clk;

  interleaved_dropout_counter #(
    .MAX_CHANNELS(MAX_CH)
  ) u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .action     (action),
    .sample     (sample),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .channel    (channel),
    .frame_lost (frame_lost),
    .lost_total (lost_total),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Monitor both channels and the register port, drive the receiver stall.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < out_idle_pct);
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.set_register(cfg_index, cfg_data);
      if (in_valid && !in_stall) sb.note_sample(action, sample);
      if (out_valid && !out_stall) sb.check_result(channel, frame_lost, lost_total);
    end
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= IDLE_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task automatic send_sample(logic [1:0] act, logic [23:0] smp);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    action   <= act;
    sample   <= smp;
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid and wait until every result beat has come back.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(logic [6:0] chans, logic [15:0] frame);
    logic [8:0] junk;
    junk = 9'($urandom);
    wait_idle();
    write_reg(idc_pkg::REG_CHANNEL_COUNT, {junk, chans});
    write_reg(idc_pkg::REG_FRAME_SIZE, frame);
  endtask

  task automatic random_config();
    int unsigned pick;
    logic [6:0]  chans;
    logic [15:0] frame;
    pick = $urandom_range(9);
    case (pick)
      0: chans = 7'd0;
      1: chans = 7'd1;
      2: chans = 7'd64;
      3: chans = 7'd127;
      4: chans = 7'd2;
      default: chans = 7'($urandom_range(1, 64));
    endcase
    frame = ($urandom_range(99) < 10) ? 16'hFFFF : 16'($urandom_range(1, 6));
    set_config(chans, frame);
  endtask

  // Mostly zeros so that runs reach the frame size; rare file and
  // measurement starts break the sequence.
  task automatic run_random(int unsigned count);
    logic [1:0]  act;
    logic [23:0] smp;
    repeat (count) begin
      act = ($urandom_range(99) < 3) ? 2'($urandom_range(1, 3)) : idc_pkg::ACT_NEXT;
      smp = ($urandom_range(99) < 80) ? 24'd0 : 24'($urandom);
      send_sample(act, smp);
    end
  endtask

  task automatic send_zeros(int unsigned count);
    repeat (count) send_sample(idc_pkg::ACT_NEXT, 24'd0);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    in_idle_pct  = 7;
    out_idle_pct = 69;

    // Every zero completes a frame; sample extremes and all action codes
    set_config(7'd1, 16'd1);
    send_sample(idc_pkg::ACT_NEXT, 24'd0);
    send_sample(idc_pkg::ACT_NEXT, 24'h800000);
    send_sample(idc_pkg::ACT_NEXT, 24'h7FFFFF);
    send_sample(idc_pkg::ACT_NEXT, 24'hFFFFFF);
    send_sample(idc_pkg::ACT_NEXT, 24'd1);
    send_sample(idc_pkg::ACT_NEXT, 24'd0);
    send_sample(idc_pkg::ACT_FILE, 24'd0);
    send_sample(idc_pkg::ACT_MEAS, 24'd0);
    send_sample(idc_pkg::ACT_MEAS_ALT, 24'd0);
    send_sample(idc_pkg::ACT_FILE, 24'h123456);

    // Leave the pointer at 7, then shrink the count under it
    set_config(7'd10, 16'd2);
    send_zeros(7);
    set_config(7'd3, 16'd2);
    send_zeros(2);

    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          in_idle_pct  = 7;
          out_idle_pct = 69;
        end
        1: begin
          in_idle_pct  = 69;
          out_idle_pct = 7;
        end
        default: begin
          in_idle_pct  = 0;
          out_idle_pct = 0;
        end
      endcase
      repeat (5) begin
        random_config();
        run_random(105);
      end
    end

    // Zero frame size: a nonzero sample leaves the run at zero and matches
    set_config(7'd1, 16'd0);
    send_zeros(8);
    send_sample(idc_pkg::ACT_NEXT, 24'd3);
    send_sample(idc_pkg::ACT_NEXT, 24'h800000);
    send_zeros(8);
    // Run left above a reduced frame size keeps counting past it
    set_config(7'd1, 16'd20);
    send_zeros(12);
    set_config(7'd1, 16'd5);
    send_zeros(20);

    wait_idle();
    repeat (10) @(posedge clk);
    if (sb.fails == 0 && sb.outstanding() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: interleaved_dropout_counter.f
hw/rtl/idc_pkg.sv
hw/rtl/idc_ram.sv
hw/rtl/interleaved_dropout_counter.sv
verif/tb_interleaved_dropout_counter.sv
